// ===== src/ffba_pkg.sv =====
// Shared types and constants of the first-fit block allocator.
// Used by the map store, the datapath, the controller and the top level.
package ffba_pkg;

    // pool geometry
    localparam int POOL_BLOCKS = 64;
    localparam int IDX_W = $clog2(POOL_BLOCKS);
    localparam int CNT_W = $clog2(POOL_BLOCKS + 1);

    // fixed widths of the word fields
    localparam int COUNT_W  = 7;
    localparam int HANDLE_W = 7;
    localparam int STATUS_W = 3;
    localparam int HEAD_W   = 6;
    localparam int SUM_W    = 7;

    // width for comparing internal counts with word fields
    localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    typedef enum logic [1:0] {
        KIND_EMPTY    = 2'd0,
        KIND_SINGLE   = 2'd1,
        KIND_HEAD     = 2'd2,
        KIND_TRAILING = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_ZERO_COUNT = 3'd1,
        ST_NO_SPACE   = 3'd2,
        ST_NULL       = 3'd3,
        ST_NOT_FOUND  = 3'd4,
        ST_NOT_HEAD   = 3'd5
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    // one map entry
    typedef struct packed {
        kind_t            kind;
        logic [CNT_W-1:0] len;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic    load;          // latch the input word
        logic    scan_start;    // start a pass over the map
        logic    scan_fit;      // that pass also looks for a first fit
        logic    mark_start;    // write the chosen run
        logic    clear_start;   // release the run at the handle
        logic    commit_stats;  // keep the totals of the pass just done
        logic    emit;          // load the result register
        status_t status;        // status of the result
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic op_free;
        logic is_null;
        logic idx_oob;
        logic count_zero;
        logic count_fits;
        logic head_ok;
        logic fit_found;
        logic scan_busy;
        logic wr_busy;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== src/ffba_map.sv =====
// Block status map: one entry per pool block, kind and run length.
// Memory with one write and one registered read port, valid bits cleared
// at reset so that unwritten entries read empty. Depends on ffba_pkg.
module ffba_map (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [ffba_pkg::IDX_W-1:0] rd_addr,
    output ffba_pkg::entry_t           rd_entry,
    input  logic                       wr_set,
    input  logic                       wr_clr,
    input  logic [ffba_pkg::IDX_W-1:0] wr_addr,
    input  ffba_pkg::entry_t           wr_entry
);
    import ffba_pkg::*;

    entry_t                 mem [POOL_BLOCKS];
    logic [POOL_BLOCKS-1:0] valid_reg;
    entry_t                 rd_word_reg;
    logic                   rd_valid_reg;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_set) begin
                valid_reg[wr_addr] <= 1'b1;
            end else if (wr_clr) begin
                valid_reg[wr_addr] <= 1'b0;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (wr_set) begin
            mem[wr_addr] <= wr_entry;
        end
        rd_word_reg <= mem[rd_addr];
    end

    // an entry never written reads as empty
    always_comb begin
        if (rd_valid_reg) begin
            rd_entry = rd_word_reg;
        end else begin
            rd_entry.kind = KIND_EMPTY;
            rd_entry.len  = '0;
        end
    end

endmodule

// ===== src/ffba_datapath.sv =====
// Datapath: input latch, map scanner, run writer, totals and result register.
// Depends on ffba_pkg and ffba_map.
module ffba_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ffba_pkg::dp_cmd_t             cmd,
    output ffba_pkg::dp_stat_t            stat,
    input  logic                          in_opcode,
    input  logic [ffba_pkg::COUNT_W-1:0]  in_count,
    input  logic [ffba_pkg::HANDLE_W-1:0] in_handle,
    input  logic                          in_null,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ffba_pkg::STATUS_W-1:0] out_status,
    output logic [ffba_pkg::HEAD_W-1:0]   out_head,
    output logic [ffba_pkg::SUM_W-1:0]    out_free_blocks,
    output logic [ffba_pkg::SUM_W-1:0]    out_largest
);
    import ffba_pkg::*;

    // latched request
    opcode_t             op_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic                null_reg;

    // scanner
    logic             scan_run_reg;
    logic             scan_fit_reg;
    logic [IDX_W-1:0] scan_addr_reg;
    logic             pend_reg;
    logic             pend_last_reg;
    logic [IDX_W-1:0] pend_idx_reg;
    logic [CNT_W-1:0] cur_reg, best_reg, total_reg;
    logic [IDX_W-1:0] start_reg;
    logic             found_reg;
    logic [IDX_W-1:0] fit_head_reg;

    // writer
    logic             wr_run_reg;
    logic             wr_mark_reg;
    logic [IDX_W-1:0] wr_addr_reg;
    logic [CNT_W-1:0] wr_left_reg;

    // totals after the last operation
    logic [CNT_W-1:0] stat_total_reg, stat_best_reg;

    // result register
    logic                out_valid_reg;
    status_t             out_status_reg;
    logic [HEAD_W-1:0]   out_head_reg;
    logic [SUM_W-1:0]    out_free_reg;
    logic [SUM_W-1:0]    out_largest_reg;

    // map
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_entry;
    logic             wr_set, wr_clr;
    entry_t           wr_entry;
    logic             rd_empty;
    logic [CNT_W-1:0] cur_next;
    logic [IDX_W-1:0] start_next;
    logic             wr_last;

    ffba_map u_map (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry),
        .wr_set   (wr_set),
        .wr_clr   (wr_clr),
        .wr_addr  (wr_addr_reg),
        .wr_entry (wr_entry)
    );

    // read address: scanner while it runs, else the handle
    assign rd_addr = scan_run_reg ? scan_addr_reg : IDX_W'(handle_reg);

    // request latch
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg     <= opcode_t'(in_opcode);
            count_reg  <= in_count;
            handle_reg <= in_handle;
            null_reg   <= in_null;
        end
    end

    // run tracking of the entry arriving from the map
    assign rd_empty   = (rd_entry.kind == KIND_EMPTY);
    assign cur_next   = rd_empty ? cur_reg + 1'b1 : '0;
    assign start_next = (cur_reg == '0) ? pend_idx_reg : start_reg;

    // scanner: issues one read a cycle, folds each entry in the cycle after its read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_run_reg <= 1'b0;
            pend_reg     <= 1'b0;
        end else begin
            if (cmd.scan_start) begin
                scan_run_reg <= 1'b1;
            end else if (scan_run_reg && scan_addr_reg == IDX_W'(POOL_BLOCKS - 1)) begin
                scan_run_reg <= 1'b0;
            end
            pend_reg <= scan_run_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_start) begin
            scan_addr_reg <= '0;
            scan_fit_reg  <= cmd.scan_fit;
            cur_reg       <= '0;
            best_reg      <= '0;
            total_reg     <= '0;
            start_reg     <= '0;
            if (cmd.scan_fit) begin
                found_reg    <= 1'b0;
                fit_head_reg <= '0;
            end
        end else begin
            if (scan_run_reg) begin
                scan_addr_reg <= scan_addr_reg + 1'b1;
            end
            if (pend_reg) begin
                cur_reg   <= cur_next;
                start_reg <= start_next;
                if (rd_empty) begin
                    total_reg <= total_reg + 1'b1;
                end
                if (cur_next > best_reg) begin
                    best_reg <= cur_next;
                end
                // first run that reaches the requested length
                if (scan_fit_reg && !found_reg && rd_empty &&
                    CMP_W'(cur_next) >= CMP_W'(count_reg)) begin
                    found_reg    <= 1'b1;
                    fit_head_reg <= start_next;
                end
            end
        end
        pend_idx_reg  <= scan_addr_reg;
        pend_last_reg <= scan_run_reg && scan_addr_reg == IDX_W'(POOL_BLOCKS - 1);
    end

    // writer: one entry a cycle, stops at the run end or the pool end
    assign wr_last = (wr_left_reg == CNT_W'(1)) ||
                     (wr_addr_reg == IDX_W'(POOL_BLOCKS - 1));
    assign wr_set  = wr_run_reg && wr_mark_reg && (wr_left_reg != '0);
    assign wr_clr  = wr_run_reg && !wr_mark_reg && (wr_left_reg != '0);

    always_comb begin
        wr_entry.len = CNT_W'(count_reg);
        if (wr_addr_reg != fit_head_reg) begin
            wr_entry.kind = KIND_TRAILING;
        end else if (count_reg == COUNT_W'(1)) begin
            wr_entry.kind = KIND_SINGLE;
        end else begin
            wr_entry.kind = KIND_HEAD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_run_reg <= 1'b0;
        end else if (cmd.mark_start || cmd.clear_start) begin
            wr_run_reg <= 1'b1;
        end else if (wr_run_reg && (wr_last || wr_left_reg == '0)) begin
            wr_run_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mark_start) begin
            wr_mark_reg <= 1'b1;
            wr_addr_reg <= fit_head_reg;
            wr_left_reg <= CNT_W'(count_reg);
        end else if (cmd.clear_start) begin
            wr_mark_reg <= 1'b0;
            wr_addr_reg <= IDX_W'(handle_reg);
            wr_left_reg <= rd_entry.len;
        end else if (wr_run_reg) begin
            wr_addr_reg <= wr_addr_reg + 1'b1;
            wr_left_reg <= wr_left_reg - 1'b1;
        end
    end

    // totals of the map as it stands
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stat_total_reg <= CNT_W'(POOL_BLOCKS);
            stat_best_reg  <= CNT_W'(POOL_BLOCKS);
        end else if (cmd.commit_stats) begin
            stat_total_reg <= total_reg;
            stat_best_reg  <= best_reg;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_status_reg  <= cmd.status;
            out_head_reg    <= (cmd.status == ST_OK && op_reg == OP_ALLOC) ?
                               HEAD_W'(fit_head_reg) : '0;
            out_free_reg    <= SUM_W'(stat_total_reg);
            out_largest_reg <= SUM_W'(stat_best_reg);
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_status      = out_status_reg;
    assign out_head        = out_head_reg;
    assign out_free_blocks = out_free_reg;
    assign out_largest     = out_largest_reg;

    // status toward the controller
    assign stat.op_free    = (op_reg == OP_FREE);
    assign stat.is_null    = null_reg;
    assign stat.idx_oob    = CMP_W'(handle_reg) >= CMP_W'(POOL_BLOCKS);
    assign stat.count_zero = (count_reg == '0);
    assign stat.count_fits = CMP_W'(count_reg) <= CMP_W'(stat_best_reg);
    assign stat.head_ok    = (rd_entry.kind == KIND_SINGLE) ||
                             (rd_entry.kind == KIND_HEAD);
    assign stat.fit_found  = found_reg;
    assign stat.scan_busy  = scan_run_reg || pend_reg;
    assign stat.wr_busy    = wr_run_reg;
    assign stat.out_free   = !out_valid_reg || out_ready;

    // scanning and writing never overlap
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(stat.scan_busy && wr_run_reg))
        else $error("map scan and run write active together");

    // the longest empty run never exceeds the empty total
    a_best_le_total: assert property (@(posedge aclk) disable iff (!aresetn)
        stat_best_reg <= stat_total_reg)
        else $error("largest free run above free block count");

    // a write pass always starts with a nonzero length
    a_wr_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.mark_start || cmd.clear_start) |=> wr_left_reg != '0)
        else $error("run write started with zero length");

    // when the last scanned entry is folded, the scanner no longer issues reads
    a_scan_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_last_reg && pend_reg && !cmd.scan_start) |-> !scan_run_reg)
        else $error("scanner still issuing after last entry");

endmodule

// ===== src/ffba_ctrl.sv =====
// Controller of the first-fit block allocator: sequences decode, fit scan, free check,
// run write, totals scan and result. Depends on ffba_pkg.
module ffba_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  ffba_pkg::dp_stat_t stat,
    output ffba_pkg::dp_cmd_t  cmd
);
    import ffba_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FIT_SCAN,
        S_FREE_CHECK,
        S_WRITE,
        S_STAT_SCAN,
        S_EMIT
    } state_t;

    state_t  state_reg, state_next;
    status_t code_reg, code_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        code_next  = code_reg;
        cmd        = '0;
        cmd.status = code_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    code_next  = ST_OK;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                if (stat.op_free) begin
                    priority if (stat.is_null) begin
                        code_next  = ST_NULL;
                        state_next = S_EMIT;
                    end else if (stat.idx_oob) begin
                        code_next  = ST_NOT_FOUND;
                        state_next = S_EMIT;
                    end else begin
                        state_next = S_FREE_CHECK;
                    end
                end else begin
                    priority if (stat.count_zero) begin
                        code_next  = ST_ZERO_COUNT;
                        state_next = S_EMIT;
                    end else if (!stat.count_fits) begin
                        code_next  = ST_NO_SPACE;
                        state_next = S_EMIT;
                    end else begin
                        cmd.scan_start = 1'b1;
                        cmd.scan_fit   = 1'b1;
                        state_next     = S_FIT_SCAN;
                    end
                end
            end
            S_FIT_SCAN: begin
                if (!stat.scan_busy) begin
                    if (stat.fit_found) begin
                        cmd.mark_start = 1'b1;
                        state_next     = S_WRITE;
                    end else begin
                        code_next  = ST_NO_SPACE;
                        state_next = S_EMIT;
                    end
                end
            end
            S_FREE_CHECK: begin
                if (stat.head_ok) begin
                    cmd.clear_start = 1'b1;
                    state_next      = S_WRITE;
                end else begin
                    code_next  = ST_NOT_HEAD;
                    state_next = S_EMIT;
                end
            end
            S_WRITE: begin
                if (!stat.wr_busy) begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_STAT_SCAN;
                end
            end
            S_STAT_SCAN: begin
                if (!stat.scan_busy) begin
                    cmd.commit_stats = 1'b1;
                    state_next       = S_EMIT;
                end
            end
            S_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and held status code
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            code_reg  <= ST_OK;
        end else begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // a word is taken only when the controller is idle
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> state_reg == S_IDLE)
        else $error("word loaded outside idle");

    // a result is loaded only when the output slot is free
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> stat.out_free)
        else $error("result loaded over a waiting word");

    // a successful operation passes through the totals scan
    a_ok_scanned: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && code_reg == ST_OK) |-> $past(state_reg) == S_STAT_SCAN
        || $past(state_reg) == S_EMIT)
        else $error("ok result without a totals scan");

endmodule

// ===== src/first_fit_block_allocator_core.sv =====
// First-fit contiguous block allocator over a pool of ffba_pkg::POOL_BLOCKS
// blocks (64). One request at a time; each request gives exactly one result
// word. An allocate that succeeds makes a first-fit pass over the map, a
// write of the run one entry a cycle, and a second pass for the new free
// totals, all through the single read port of the map memory. A free that
// succeeds clears its run and then makes the totals pass. Requests that fail
// their checks (zero count, no fitting run, null or outside handle, not a
// head) leave the map as it is. The map reads as all empty right after reset,
// with no clearing pass.
// Depends on ffba_pkg, ffba_ctrl, ffba_datapath.
module first_fit_block_allocator_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // block_count[6:0], handle_index[13:7],
                                   // handle_is_null[14], zero[15]
    input  logic [0:0]  s_tuser,   // opcode[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // status[2:0], head_index[8:3],
                                   // free_blocks[15:9], largest_free_run[22:16],
                                   // zero[23]
);
    import ffba_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    logic [STATUS_W-1:0] out_status;
    logic [HEAD_W-1:0]   out_head;
    logic [SUM_W-1:0]    out_free_blocks;
    logic [SUM_W-1:0]    out_largest;

    ffba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ffba_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .in_opcode       (s_tuser[0]),
        .in_count        (s_tdata[6:0]),
        .in_handle       (s_tdata[13:7]),
        .in_null         (s_tdata[14]),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_status      (out_status),
        .out_head        (out_head),
        .out_free_blocks (out_free_blocks),
        .out_largest     (out_largest)
    );

    // result word packing
    assign m_tdata = {1'b0, out_largest, out_free_blocks, out_head, out_status};

endmodule
